FILE: sv/client_health_rate_limiter_assert.svh
// Assertion macros for the client health rate limiter.
// Included by the modules that carry concurrent assertions; uses their clk and rst_n.
`ifndef CLIENT_HEALTH_RATE_LIMITER_ASSERT_SVH
`define CLIENT_HEALTH_RATE_LIMITER_ASSERT_SVH

// Checked at every rising edge once reset has been released.
`define CHRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, during reset as well.
`define CHRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/chrl_pkg.sv
// Shared types and constants of the client health rate limiter.
// Used by every module of the block; depends on nothing else.
package chrl_pkg;

  // Fixed field widths.
  localparam int SLOT_W     = 8;
  localparam int NOW_W      = 40;
  localparam int HEALTH_W   = 15;
  localparam int GAP_W      = 20;
  localparam int STEP_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Number of slots a client_slot field can name.
  localparam int SLOT_SPAN = 1 << SLOT_W;

  // Parameter defaults for the top level.
  localparam int DEF_NUM_CLIENTS = 256;
  localparam int DEF_TIME_BITS   = 40;

  // Health is fixed point with 8 fraction bits; 100.0 is full health.
  localparam logic [HEALTH_W-1:0] FULL_HEALTH = 15'd25600;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD  = 2'd2;

  // Register reset values.
  localparam logic [GAP_W-1:0]  RST_MIN_GAP = 20'd1000;
  localparam logic [STEP_W-1:0] RST_PENALTY = 15'd2560;
  localparam logic [STEP_W-1:0] RST_REWARD  = 15'd1280;

  // Configuration register contents.
  typedef struct packed {
    logic [GAP_W-1:0]  min_gap;
    logic [STEP_W-1:0] penalty;
    logic [STEP_W-1:0] reward;
  } chrl_cfg_t;

  // Outcome of one health update.
  typedef struct packed {
    logic                write;
    logic                accepted;
    logic [HEALTH_W-1:0] health;
  } chrl_res_t;

endpackage

FILE: sv/chrl_cfg.sv
// Configuration registers of the client health rate limiter.
// Depends on chrl_pkg for the register indexes, reset values and the register struct.
module chrl_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [chrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output chrl_pkg::chrl_cfg_t            cfg_o
);
  import chrl_pkg::*;

  chrl_cfg_t cfg_r;
  chrl_cfg_t cfg_nxt;

  // Decode a write transaction; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_GAP: cfg_nxt.min_gap = cfg_wdata[GAP_W-1:0];
        CFG_PENALTY: cfg_nxt.penalty = cfg_wdata[STEP_W-1:0];
        CFG_REWARD:  cfg_nxt.reward  = cfg_wdata[STEP_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap <= RST_MIN_GAP;
      cfg_r.penalty <= RST_PENALTY;
      cfg_r.reward  <= RST_REWARD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: sv/chrl_table.sv
// Per-client state table: health and last accepted time in a synchronous memory.
// Depends on chrl_pkg; valid bits give never-written entries their reset values.
module chrl_table #(
  parameter int DEPTH     = chrl_pkg::DEF_NUM_CLIENTS,
  parameter int TIME_BITS = chrl_pkg::DEF_TIME_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [chrl_pkg::HEALTH_W-1:0] wr_health,
  input  logic [TIME_BITS-1:0]          wr_time,
  output logic [chrl_pkg::HEALTH_W-1:0] rd_health,
  output logic [TIME_BITS-1:0]          rd_time
);
  import chrl_pkg::*;

  logic [HEALTH_W-1:0]  health_mem [DEPTH];
  logic [TIME_BITS-1:0] time_mem   [DEPTH];

  logic [DEPTH-1:0]     vld_r;
  logic                 rd_vld_r;
  logic                 fwd_hit_r;
  logic [HEALTH_W-1:0]  rd_health_r;
  logic [TIME_BITS-1:0] rd_time_r;
  logic [HEALTH_W-1:0]  fwd_health_r;
  logic [TIME_BITS-1:0] fwd_time_r;

  // Memory: one write and one registered read per cycle, read returns old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      health_mem[wr_addr] <= wr_health;
      time_mem[wr_addr]   <= wr_time;
    end
    if (rd_en) begin
      rd_health_r <= health_mem[rd_addr];
      rd_time_r   <= time_mem[rd_addr];
    end
  end

  // Valid bits and the forwarding flag for a write made at the read edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // Data of the write that coincides with a read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_health_r <= wr_health;
      fwd_time_r   <= wr_time;
    end
  end

  // Forwarded data wins; an entry never written reads as full health and time zero.
  always_comb begin
    if (fwd_hit_r) begin
      rd_health = fwd_health_r;
      rd_time   = fwd_time_r;
    end else if (rd_vld_r) begin
      rd_health = rd_health_r;
      rd_time   = rd_time_r;
    end else begin
      rd_health = FULL_HEALTH;
      rd_time   = '0;
    end
  end

endmodule

FILE: sv/chrl_update.sv
// Health update of one request: gap test, penalty, capped reward or no change for a first request, accept decision.
// Depends on chrl_pkg for the register struct, the result struct and full health.
module chrl_update #(
  parameter int TIME_BITS = chrl_pkg::DEF_TIME_BITS
) (
  input  chrl_pkg::chrl_cfg_t           cfg_i,
  input  logic                          in_range,
  input  logic [chrl_pkg::HEALTH_W-1:0] health_old,
  input  logic [TIME_BITS-1:0]          last_time,
  input  logic [TIME_BITS-1:0]          now_time,
  output chrl_pkg::chrl_res_t           res_o,
  output logic [TIME_BITS-1:0]          time_new
);
  import chrl_pkg::*;

  localparam int CMP_W = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;

  logic [TIME_BITS:0]  gap;
  logic                fast;
  logic                first;
  logic [HEALTH_W:0]   sum;
  logic [HEALTH_W-1:0] health_dec;
  logic [HEALTH_W-1:0] health_inc;
  logic [HEALTH_W-1:0] health_new;

  // Gap since the last accepted request; time going backwards counts as fast.
  assign gap  = {1'b0, now_time} - {1'b0, last_time};
  assign fast = gap[TIME_BITS] ||
                (CMP_W'(gap[TIME_BITS-1:0]) < CMP_W'(cfg_i.min_gap));
  assign first = (last_time == '0);

  // Penalty saturates at zero, reward is capped at full health.
  assign health_dec = (health_old > cfg_i.penalty) ? (health_old - cfg_i.penalty) : '0;
  assign sum        = {1'b0, health_old} + {1'b0, cfg_i.reward};
  assign health_inc = (sum > {1'b0, FULL_HEALTH}) ? FULL_HEALTH : sum[HEALTH_W-1:0];

  always_comb begin
    if (first) begin
      health_new = health_old;
    end else if (fast) begin
      health_new = health_dec;
    end else begin
      health_new = health_inc;
    end
  end

  // A blocked or out-of-range client leaves the table untouched.
  always_comb begin
    res_o.write    = in_range && (health_old != '0);
    res_o.accepted = res_o.write && (health_new != '0);
    res_o.health   = res_o.write ? health_new : '0;
  end

  assign time_new = res_o.accepted ? now_time : last_time;

endmodule

FILE: sv/client_health_rate_limiter.sv
// Client health rate limiter: one result per request; out_valid rises once the request has passed
// the update stage and output registers. Throughput is one request per cycle while the output is not stalled.
// A write made at the edge where the next request reads the same slot is forwarded to it.
// Reset is synchronous: registers return to their defaults and all slot valid bits clear,
// so every slot reads full health and no timestamp at once; there is no clearing pass.
`include "client_health_rate_limiter_assert.svh"

module client_health_rate_limiter #(
  parameter int NUM_CLIENTS = chrl_pkg::DEF_NUM_CLIENTS,
  parameter int TIME_BITS   = chrl_pkg::DEF_TIME_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [chrl_pkg::SLOT_W-1:0]     in_client_slot,
  input  logic [chrl_pkg::NOW_W-1:0]      in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [chrl_pkg::HEALTH_W-1:0]   out_health_after,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [chrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chrl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import chrl_pkg::*;

  // Only slots that the slot field can name need storage.
  localparam int DEPTH = (NUM_CLIENTS < SLOT_SPAN) ? NUM_CLIENTS : SLOT_SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  chrl_cfg_t            cfg;
  chrl_res_t            res;
  logic                 in_accept;
  logic                 s1_adv;
  logic                 wr_en;
  logic [HEALTH_W-1:0]  rd_health;
  logic [TIME_BITS-1:0] rd_time;
  logic [TIME_BITS-1:0] time_new;

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_range_r;
  logic [AW-1:0]        s1_addr_r;
  logic [TIME_BITS-1:0] s1_now_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_accepted_r;
  logic [HEALTH_W-1:0]  out_health_r;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  chrl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Handshake: the update stage moves on when the output register is free or drains.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign wr_en     = s1_valid_r && s1_adv && res.write;

  chrl_table #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_accept),
    .rd_addr   (in_client_slot[AW-1:0]),
    .wr_en     (wr_en),
    .wr_addr   (s1_addr_r),
    .wr_health (res.health),
    .wr_time   (time_new),
    .rd_health (rd_health),
    .rd_time   (rd_time)
  );

  chrl_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .cfg_i      (cfg),
    .in_range   (s1_range_r),
    .health_old (rd_health),
    .last_time  (rd_time),
    .now_time   (s1_now_r),
    .res_o      (res),
    .time_new   (time_new)
  );

  // Update stage: the request waits here with its table entry, which was read at the edge that took it.
  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_range_r <= ({1'b0, in_client_slot} < (SLOT_W + 1)'(DEPTH));
      s1_addr_r  <= in_client_slot[AW-1:0];
      s1_now_r   <= TIME_BITS'(in_now_ms);
    end
  end

  // Output register holds a finished result until the transaction completes.
  assign out_valid_nxt = (s1_valid_r && s1_adv) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_accepted_r <= res.accepted;
      out_health_r   <= res.health;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_health_after = out_health_r;

  // A refused request always reports zero health.
  `CHRL_ASSERT(a_refused_zero, out_valid_r && !out_accepted_r |-> out_health_r == '0, "refused result carries nonzero health")

  // An accepted request reports a positive health no higher than full.
  `CHRL_ASSERT(a_accepted_range, out_valid_r && out_accepted_r |-> (out_health_r != '0) && (out_health_r <= FULL_HEALTH), "accepted result health out of range")

  // A request held behind a stalled output keeps its stage and its time.
  `CHRL_ASSERT(a_stage_hold, s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(s1_now_r) && $stable(s1_addr_r), "update stage lost its request under stall")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the client health rate limiter.
// Depends on chrl_pkg and client_health_rate_limiter; keeps its own model of the health tables.
`timescale 1ns / 100ps

module tb_top;
  import chrl_pkg::*;

  localparam int NUM_CLIENTS    = DEF_NUM_CLIENTS;
  localparam int TIME_BITS      = DEF_TIME_BITS;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT    = 40;
  localparam int NUM_DIRECTED   = 25;

  // Register index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [NOW_W-1:0] TIME_MASK = {NOW_W{1'b1}} >> (NOW_W - TIME_BITS);

  typedef struct packed {
    logic                accepted;
    logic [HEALTH_W-1:0] health;
  } health_verdict_t;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [NOW_W-1:0]    now;
    logic                typed;
    logic                accepted;
    logic [HEALTH_W-1:0] health;
  } directed_row_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [SLOT_W-1:0]     in_client_slot   = '0;
  logic [NOW_W-1:0]      in_now_ms        = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic                  out_accepted;
  logic [HEALTH_W-1:0]   out_health_after;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;

  // Expected result of the transaction currently on the input, for typed rows.
  logic                  row_typed        = 1'b0;
  logic                  row_accepted     = 1'b0;
  logic [HEALTH_W-1:0]   row_health       = '0;

  // Model state: health and last accepted time per client, and the live registers.
  logic [HEALTH_W-1:0]   shadow_health [NUM_CLIENTS];
  logic [NOW_W-1:0]      shadow_stamp  [NUM_CLIENTS];
  logic [GAP_W-1:0]      cur_min_gap;
  logic [STEP_W-1:0]     cur_penalty;
  logic [STEP_W-1:0]     cur_reward;

  // Time most recently sent for each slot, used to pace well-formed request streams.
  logic [NOW_W-1:0]      slot_clock [SLOT_SPAN];

  health_verdict_t       pending_verdicts [$];
  int                    error_count  = 0;
  int                    quiet_cycles = 0;
  int                    stall_left   = 0;
  int                    stall_mode   = 0;

  // Defaults give min gap 1000, penalty 2560 (10.0) and reward 1280 (5.0).
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'd0,   40'd1,             1'b1, 1'b1, 15'd25600},  // first request keeps health
    '{8'd0,   40'd2,             1'b1, 1'b1, 15'd23040},  // too fast
    '{8'd0,   40'd1002,          1'b1, 1'b1, 15'd24320},  // gap equal to threshold
    '{8'd0,   40'd1000000,       1'b1, 1'b1, 15'd25600},  // reward lands on full health
    '{8'd0,   40'd2000000,       1'b1, 1'b1, 15'd25600},  // reward capped
    '{8'd0,   40'd2000999,       1'b1, 1'b1, 15'd23040},  // one below threshold
    '{8'd255, 40'hFF_FFFF_FFFF,  1'b1, 1'b1, 15'd25600},  // top slot, latest time
    '{8'd255, 40'd1,             1'b1, 1'b1, 15'd23040},  // time going backwards
    '{8'd1,   40'd0,             1'b1, 1'b1, 15'd25600},  // zero time accepted
    '{8'd1,   40'd3,             1'b1, 1'b1, 15'd25600},  // stamp of zero counts as first
    '{8'd1,   40'd4,             1'b1, 1'b1, 15'd23040},
    '{8'd2,   40'd10,            1'b1, 1'b1, 15'd25600},
    '{8'd2,   40'd11,            1'b0, 1'b0, 15'd0},      // drain slot 2 step by step
    '{8'd2,   40'd12,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd13,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd14,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd15,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd16,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd17,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd18,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd19,            1'b0, 1'b0, 15'd0},
    '{8'd2,   40'd20,            1'b1, 1'b0, 15'd0},      // penalty equal to health: blocked
    '{8'd2,   40'd100000,        1'b1, 1'b0, 15'd0},      // blocked client stays blocked
    '{8'd3,   40'h55_5555_5555,  1'b1, 1'b1, 15'd25600},
    '{8'd3,   40'hAA_AAAA_AAAA,  1'b1, 1'b1, 15'd25600}
  };

  client_health_rate_limiter #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .TIME_BITS   (TIME_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_client_slot   (in_client_slot),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_health_after (out_health_after),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // Applies one request to the model tables and returns the result it should give.
  function automatic health_verdict_t grade_request(input logic [SLOT_W-1:0] slot,
                                                    input logic [NOW_W-1:0]  now_raw);
    health_verdict_t  verdict;
    logic [NOW_W-1:0] now;
    logic [NOW_W-1:0] last;
    logic [NOW_W-1:0] elapsed;
    logic [16:0]      level;
    logic             too_fast;
    verdict = '0;
    now     = now_raw & TIME_MASK;
    if (int'(slot) >= NUM_CLIENTS) begin
      return verdict;
    end
    level = {2'b00, shadow_health[slot]};
    if (level == '0) begin
      return verdict;
    end
    // A client with a stamp of zero (never accepted, or accepted at time zero) keeps its health on this request.
    last = shadow_stamp[slot];
    if (last != '0) begin
      elapsed  = now - last;
      too_fast = (now < last) || (elapsed < cur_min_gap);
      if (too_fast) begin
        level = (level > cur_penalty) ? level - cur_penalty : '0;
      end else begin
        level = level + cur_reward;
        if (level > FULL_HEALTH) begin
          level = FULL_HEALTH;
        end
      end
    end
    shadow_health[slot] = level[HEALTH_W-1:0];
    if (level == '0) begin
      return verdict;
    end
    shadow_stamp[slot] = now;
    verdict.accepted   = 1'b1;
    verdict.health     = level[HEALTH_W-1:0];
    return verdict;
  endfunction

  // Fills the bits above a register's width with noise; the block must ignore them.
  function automatic logic [CFG_DATA_W-1:0] pad_register(input logic [CFG_DATA_W-1:0] value,
                                                         input int width);
    return (CFG_DATA_W'($urandom) << width) | value;
  endfunction

  // Presents one request and returns at the falling edge after it has been taken.
  task automatic send_request(input logic [SLOT_W-1:0]   slot,
                              input logic [NOW_W-1:0]    now,
                              input logic                typed,
                              input logic                accepted,
                              input logic [HEALTH_W-1:0] health);
    in_valid       <= 1'b1;
    in_client_slot <= slot;
    in_now_ms      <= now;
    row_typed      <= typed;
    row_accepted   <= accepted;
    row_health     <= health;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes one register and mirrors the write into the model.
  task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_GAP: cur_min_gap = data[GAP_W-1:0];
      CFG_PENALTY: cur_penalty = data[STEP_W-1:0];
      CFG_REWARD:  cur_reward  = data[STEP_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived, then lets the pipeline settle.
  task automatic wait_for_quiet();
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Reprograms the registers, then sends a random stream aimed mostly at a pool of slots.
  task automatic run_phase(input logic [GAP_W-1:0]  min_gap,
                           input logic [STEP_W-1:0] penalty,
                           input logic [STEP_W-1:0] reward,
                           input int                count,
                           input int                pool_base,
                           input int                pool_size);
    logic [SLOT_W-1:0] slot;
    logic [NOW_W-1:0]  now;
    logic [NOW_W-1:0]  step;
    logic [63:0]       wide;
    int                pick;
    int                pause;
    int                burst_left;
    burst_left = 0;
    wait_for_quiet();
    write_register(CFG_MIN_GAP, pad_register(CFG_DATA_W'(min_gap), GAP_W));
    write_register(CFG_PENALTY, pad_register(CFG_DATA_W'(penalty), STEP_W));
    write_register(CFG_REWARD,  pad_register(CFG_DATA_W'(reward),  STEP_W));
    write_register(CFG_UNUSED,  CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    for (int n = 0; n < count; n++) begin
      // The sender works in bursts, with a gap of random length between them.
      if (burst_left == 0) begin
        pause = $urandom_range(0, 12);
        if (pause != 0) begin
          in_valid <= 1'b0;
          repeat (pause) @(negedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      if ($urandom_range(0, 4) == 0) begin
        slot = SLOT_W'($urandom);
      end else begin
        slot = SLOT_W'(pool_base + $urandom_range(0, pool_size - 1));
      end
      // Mostly paced requests around the threshold; some noise, zero and backward times.
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        wide = {$urandom, $urandom};
        now  = wide[NOW_W-1:0];
      end else if (pick < 10) begin
        now = '0;
      end else if (pick < 14) begin
        now = slot_clock[slot] - NOW_W'($urandom_range(1, 1000));
      end else begin
        if (pick < 49) begin
          step = (cur_min_gap == '0) ? '0 : NOW_W'($urandom_range(0, cur_min_gap - 1));
        end else if (pick < 56) begin
          step = NOW_W'(cur_min_gap);
        end else if (pick < 60) begin
          step = (cur_min_gap == '0) ? '0 : NOW_W'(cur_min_gap - 1);
        end else begin
          step = NOW_W'(cur_min_gap) + NOW_W'($urandom_range(0, 3000));
        end
        now = slot_clock[slot] + step;
      end
      slot_clock[slot] = now;
      send_request(slot, now, 1'b0, 1'b0, '0);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // Every request transaction is graded by the model as it is taken.
  always @(posedge clk) begin : request_monitor
    health_verdict_t verdict;
    if (rst_n && in_valid && !in_stall) begin
      verdict = grade_request(in_client_slot, in_now_ms);
      if (row_typed) begin
        pending_verdicts.push_back('{row_accepted, row_health});
      end else begin
        pending_verdicts.push_back(verdict);
      end
    end
  end

  // Every result transaction is compared with the oldest expectation.
  always @(posedge clk) begin : result_checker
    health_verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        flag_error($sformatf("unexpected result: accepted %0b health %0d",
                             out_accepted, out_health_after));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_accepted !== want.accepted) begin
          flag_error($sformatf("accepted is %0b, expected %0b", out_accepted, want.accepted));
        end
        if (out_health_after !== want.health) begin
          flag_error($sformatf("health_after is %0d, expected %0d",
                               out_health_after, want.health));
        end
      end
    end
  end

  // The receiver alternates between free-running, held and chattering stretches.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 40);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'b1;
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  // Ends the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        flag_error($sformatf("timeout with %0d results outstanding", pending_verdicts.size()));
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : sequencer
    logic [GAP_W-1:0]  rand_gap;
    logic [STEP_W-1:0] rand_penalty;
    logic [STEP_W-1:0] rand_reward;
    for (int s = 0; s < NUM_CLIENTS; s++) begin
      shadow_health[s] = FULL_HEALTH;
      shadow_stamp[s]  = '0;
    end
    for (int s = 0; s < SLOT_SPAN; s++) begin
      slot_clock[s] = '0;
    end
    cur_min_gap = RST_MIN_GAP;
    cur_penalty = RST_PENALTY;
    cur_reward  = RST_REWARD;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests run back to back under the reset register values.
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].slot, directed_rows[r].now, directed_rows[r].typed,
                   directed_rows[r].accepted, directed_rows[r].health);
    end
    in_valid <= 1'b0;

    run_phase(RST_MIN_GAP, RST_PENALTY, RST_REWARD, 300, 8, 16);
    // Paced requests below the gap are too fast and one penalty empties a client.
    run_phase(20'hFFFFF, 15'h7FFF, 15'd0, 150, 40, 24);
    // Only backward times are too fast; any reward tops a client up.
    run_phase(20'd0, 15'd0, 15'h7FFF, 250, 72, 16);
    run_phase(20'd1, 15'd1, 15'd1, 200, 100, 8);
    rand_gap     = GAP_W'($urandom_range(1, 5000));
    rand_penalty = STEP_W'($urandom_range(1, 8000));
    rand_reward  = STEP_W'($urandom_range(1, 8000));
    run_phase(rand_gap, rand_penalty, rand_reward, 500, 120, 32);
    run_phase(20'd50, FULL_HEALTH, FULL_HEALTH, 200, 160, 16);
    rand_gap     = GAP_W'($urandom);
    rand_penalty = STEP_W'($urandom);
    rand_reward  = STEP_W'($urandom);
    run_phase(rand_gap, rand_penalty, rand_reward, 350, 200, 48);

    wait_for_quiet();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/chrl_pkg.sv
sv/chrl_cfg.sv
sv/chrl_table.sv
sv/chrl_update.sv
sv/client_health_rate_limiter.sv
verif/tb_top.sv
